// File: rtl/pss_pkg.sv
// shared types and constants for the placement swap search block
// no dependencies; imported by pss_ctrl, pss_datapath and the top level

package pss_pkg;

   localparam int COST_BITS      = 44;
   localparam int CFG_BITS       = 7;
   localparam int CSR_INDEX_BITS = 1;

   // item kinds
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_TRIAL = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANK_COUNT = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GROUP_SIZE = 1'd1;

   localparam logic [CFG_BITS-1:0] RANK_COUNT_RESET = 7'd64;
   localparam logic [CFG_BITS-1:0] GROUP_SIZE_RESET = 7'd16;

   typedef logic [COST_BITS-1:0] cost_type;

   // controller to datapath
   typedef struct packed {
      logic take;        // latch trial info at accept
      logic load_write;  // write one matrix entry
      logic sweep_rst;
      logic clear_step;  // reset pass: clear matrix, identity placement
      logic init_step;   // start: identity placement
      logic swap_read;
      logic swap_wr_a;
      logic swap_wr_b;
      logic cost_go;
      logic decide;
      logic restore_a;
      logic restore_b;
   } pss_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic init_last;
      logic trial_ok;
      logic loop_busy;
      logic keep_old;
   } pss_status_type;

endpackage

// File: rtl/pss_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies

module pss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AddrBits = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                write_enable,
   input  logic [AddrBits-1:0] write_addr,
   input  logic [WIDTH-1:0]    write_data,
   input  logic [AddrBits-1:0] read_addr,
   output logic [WIDTH-1:0]    read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

// File: rtl/pss_ctrl.sv
// sequencing state machine for the placement swap search block
// depends on pss_pkg; drives pss_datapath through command and status structs

module pss_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              kind,
   input  pss_pkg::pss_status_type status,
   output pss_pkg::pss_cmd_type    cmd,
   output logic                    busy
);
   import pss_pkg::*;

   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_INIT      = 4'd2;
   localparam logic [3:0] S_SWAP_RD   = 4'd3;
   localparam logic [3:0] S_SWAP_WA   = 4'd4;
   localparam logic [3:0] S_SWAP_WB   = 4'd5;
   localparam logic [3:0] S_COST_GO   = 4'd6;
   localparam logic [3:0] S_COST      = 4'd7;
   localparam logic [3:0] S_DECIDE    = 4'd8;
   localparam logic [3:0] S_RESTORE_A = 4'd9;
   localparam logic [3:0] S_RESTORE_B = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.sweep_rst = 1'b1;
            if (start) begin
               cmd.take = 1'b1;
               unique case (kind)
                  KIND_LOAD:  cmd.load_write = 1'b1;
                  KIND_START: state_in = S_INIT;
                  KIND_TRIAL: state_in = S_SWAP_RD;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (status.init_last) begin
               state_in = S_COST_GO;
            end
         end
         S_SWAP_RD: begin
            cmd.swap_read = 1'b1;
            state_in = status.trial_ok ? S_SWAP_WA : S_COST_GO;
         end
         S_SWAP_WA: begin
            cmd.swap_wr_a = 1'b1;
            state_in = S_SWAP_WB;
         end
         S_SWAP_WB: begin
            cmd.swap_wr_b = 1'b1;
            state_in = S_COST_GO;
         end
         S_COST_GO: begin
            cmd.cost_go = 1'b1;
            state_in = S_COST;
         end
         S_COST: begin
            if (!status.loop_busy) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = status.keep_old ? S_RESTORE_A : S_IDLE;
         end
         S_RESTORE_A: begin
            cmd.restore_a = 1'b1;
            state_in = S_RESTORE_B;
         end
         S_RESTORE_B: begin
            cmd.restore_b = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// File: rtl/pss_datapath.sv
// datapath: config registers, traffic matrix and placement rams, pair walker,
// saturating cost accumulator and best cost; depends on pss_pkg and pss_ram

module pss_datapath #(
   parameter int MAX_RANKS   = 64,
   parameter int VOLUME_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pss_pkg::pss_cmd_type                cmd,
   output pss_pkg::pss_status_type             status,
   input  logic [1:0]                          req_kind,
   input  logic [5:0]                          req_row_rank,
   input  logic [5:0]                          req_col_rank,
   input  logic [31:0]                         req_volume,
   input  logic [5:0]                          req_swap_first,
   input  logic [5:0]                          req_swap_second,
   input  logic                                csr_write_enable,
   input  logic [pss_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pss_pkg::CFG_BITS-1:0]        csr_data,
   output logic                                rsp_strobe,
   output logic [pss_pkg::COST_BITS-1:0]       rsp_total_cost,
   output logic                                rsp_improved
);
   import pss_pkg::*;

   localparam int IdxW  = $clog2(MAX_RANKS);
   localparam int NW    = $clog2(MAX_RANKS + 1);
   localparam int Depth = MAX_RANKS * MAX_RANKS;
   localparam int AddrW = $clog2(Depth);
   localparam int WordW = (VOLUME_BITS < 32) ? VOLUME_BITS : 32;
   localparam int CW    = (NW > CFG_BITS) ? NW : CFG_BITS;
   localparam int GW    = (IdxW + 1 > CFG_BITS) ? IdxW + 1 : CFG_BITS;

   // configuration
   logic [CFG_BITS-1:0] rank_count_ff;
   logic [CFG_BITS-1:0] group_size_ff;
   logic [NW-1:0]       n_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_count_ff <= RANK_COUNT_RESET;
         group_size_ff <= GROUP_SIZE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_RANK_COUNT: rank_count_ff <= csr_data;
            CSR_GROUP_SIZE: group_size_ff <= csr_data;
            default:        rank_count_ff <= rank_count_ff;
         endcase
      end
   end

   always_comb begin
      n_eff = (CW'(rank_count_ff) > CW'(MAX_RANKS)) ? NW'(MAX_RANKS) : NW'(rank_count_ff);
   end

   // trial info
   logic [IdxW-1:0] a_ff;
   logic [IdxW-1:0] b_ff;
   logic            trial_ok_ff;
   logic            is_trial_ff;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         a_ff        <= IdxW'(req_swap_first);
         b_ff        <= IdxW'(req_swap_second);
         trial_ok_ff <= (CW'(req_swap_first) < CW'(n_eff)) &&
                        (CW'(req_swap_second) < CW'(n_eff));
         is_trial_ff <= (req_kind == KIND_TRIAL);
      end
   end

   // sweep counter for the clearing pass and identity fill
   logic [AddrW-1:0] sweep_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.sweep_rst) begin
         sweep_ff <= '0;
      end else if (cmd.clear_step || cmd.init_step) begin
         sweep_ff <= sweep_ff + AddrW'(1);
      end
   end

   // placement, kept as two identical copies for two read addresses
   logic            pl_we;
   logic [IdxW-1:0] pl_waddr;
   logic [IdxW-1:0] pl_wdata;
   logic [IdxW-1:0] pl_raddr_a;
   logic [IdxW-1:0] pl_raddr_b;
   logic [IdxW-1:0] pl_data_a;
   logic [IdxW-1:0] pl_data_b;
   logic [IdxW-1:0] pa_ff;
   logic [IdxW-1:0] pb_ff;

   logic [IdxW-1:0] i_ff;
   logic [IdxW-1:0] j_ff;

   always_comb begin
      pl_we    = 1'b0;
      pl_waddr = a_ff;
      pl_wdata = pa_ff;
      if ((cmd.clear_step && (sweep_ff < AddrW'(MAX_RANKS))) || cmd.init_step) begin
         pl_we    = 1'b1;
         pl_waddr = IdxW'(sweep_ff);
         pl_wdata = IdxW'(sweep_ff);
      end else if (cmd.swap_wr_a) begin
         pl_we    = 1'b1;
         pl_waddr = a_ff;
         pl_wdata = pl_data_b;
      end else if (cmd.swap_wr_b) begin
         pl_we    = 1'b1;
         pl_waddr = b_ff;
         pl_wdata = pa_ff;
      end else if (cmd.restore_a) begin
         pl_we    = 1'b1;
         pl_waddr = a_ff;
         pl_wdata = pa_ff;
      end else if (cmd.restore_b) begin
         pl_we    = 1'b1;
         pl_waddr = b_ff;
         pl_wdata = pb_ff;
      end
      pl_raddr_a = cmd.swap_read ? a_ff : i_ff;
      pl_raddr_b = cmd.swap_read ? b_ff : j_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.swap_wr_a) begin
         pa_ff <= pl_data_a;
         pb_ff <= pl_data_b;
      end
   end

   pss_ram #(.WIDTH(IdxW), .DEPTH(MAX_RANKS)) u_place_a (
      .clock        (clock),
      .write_enable (pl_we),
      .write_addr   (pl_waddr),
      .write_data   (pl_wdata),
      .read_addr    (pl_raddr_a),
      .read_data    (pl_data_a)
   );

   pss_ram #(.WIDTH(IdxW), .DEPTH(MAX_RANKS)) u_place_b (
      .clock        (clock),
      .write_enable (pl_we),
      .write_addr   (pl_waddr),
      .write_data   (pl_wdata),
      .read_addr    (pl_raddr_b),
      .read_data    (pl_data_b)
   );

   // traffic matrix
   logic             load_in_range;
   logic [AddrW-1:0] load_addr;
   logic             mx_we;
   logic [AddrW-1:0] mx_waddr;
   logic [WordW-1:0] mx_wdata;
   logic [AddrW-1:0] mx_raddr;
   logic [WordW-1:0] mx_rdata;

   always_comb begin
      load_in_range = (CW'(req_row_rank) < CW'(MAX_RANKS)) &&
                      (CW'(req_col_rank) < CW'(MAX_RANKS));
      load_addr = AddrW'(IdxW'(req_row_rank)) * AddrW'(MAX_RANKS) +
                  AddrW'(IdxW'(req_col_rank));
      mx_we    = cmd.clear_step || (cmd.load_write && load_in_range);
      mx_waddr = cmd.clear_step ? sweep_ff : load_addr;
      mx_wdata = cmd.clear_step ? '0 : WordW'(req_volume);
      mx_raddr = AddrW'(pl_data_a) * AddrW'(MAX_RANKS) + AddrW'(pl_data_b);
   end

   pss_ram #(.WIDTH(WordW), .DEPTH(Depth)) u_matrix (
      .clock        (clock),
      .write_enable (mx_we),
      .write_addr   (mx_waddr),
      .write_data   (mx_wdata),
      .read_addr    (mx_raddr),
      .read_data    (mx_rdata)
   );

   // slot pair walker: issue, placement read, matrix read, accumulate
   logic            active_ff;
   logic            v1_ff;
   logic            v2_ff;
   logic            same1_ff;
   logic            same2_ff;
   logic [IdxW-1:0] gi_ff;
   logic [IdxW-1:0] gj_ff;
   logic            i_last;
   logic            j_last;
   logic            gi_wrap;
   logic            gj_wrap;

   always_comb begin
      i_last  = (NW'(i_ff) + NW'(1)) == n_eff;
      j_last  = (NW'(j_ff) + NW'(1)) == n_eff;
      // group size zero never wraps, so the group is the slot itself
      gi_wrap = (GW'(gi_ff) + GW'(1)) == GW'(group_size_ff);
      gj_wrap = (GW'(gj_ff) + GW'(1)) == GW'(group_size_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
      end else begin
         v1_ff <= active_ff;
         v2_ff <= v1_ff;
         if (cmd.cost_go) begin
            active_ff <= (n_eff != '0);
         end else if (active_ff && i_last && j_last) begin
            active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      same1_ff <= (gi_ff == gj_ff);
      same2_ff <= same1_ff;
      if (cmd.cost_go) begin
         i_ff  <= '0;
         j_ff  <= '0;
         gi_ff <= '0;
         gj_ff <= '0;
      end else if (active_ff) begin
         if (j_last) begin
            j_ff  <= '0;
            gj_ff <= '0;
            i_ff  <= i_ff + IdxW'(1);
            gi_ff <= gi_wrap ? '0 : gi_ff + IdxW'(1);
         end else begin
            j_ff  <= j_ff + IdxW'(1);
            gj_ff <= gj_wrap ? '0 : gj_ff + IdxW'(1);
         end
      end
   end

   // saturating accumulator
   cost_type             acc_ff;
   logic [COST_BITS:0]   sum_wide;

   assign sum_wide = {1'b0, acc_ff} + {{(COST_BITS + 1 - WordW){1'b0}}, mx_rdata};

   always_ff @(posedge clock) begin
      if (cmd.cost_go) begin
         acc_ff <= '0;
      end else if (v2_ff && !same2_ff) begin
         acc_ff <= sum_wide[COST_BITS] ? '1 : sum_wide[COST_BITS-1:0];
      end
   end

   // decision and result
   cost_type best_ff;
   logic     better;
   logic     rsp_strobe_ff;
   cost_type rsp_total_cost_ff;
   logic     rsp_improved_ff;

   assign better = (acc_ff < best_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.decide;
         if (cmd.decide && (!is_trial_ff || better)) begin
            best_ff <= acc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         rsp_total_cost_ff <= acc_ff;
         rsp_improved_ff   <= is_trial_ff && better;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_total_cost = rsp_total_cost_ff;
   assign rsp_improved   = rsp_improved_ff;

   always_comb begin
      status.clear_last = (sweep_ff == AddrW'(Depth - 1));
      status.init_last  = (sweep_ff == AddrW'(MAX_RANKS - 1));
      status.trial_ok   = trial_ok_ff;
      status.loop_busy  = active_ff || v1_ff || v2_ff;
      status.keep_old   = is_trial_ff && trial_ok_ff && !better;
   end

   a_rsp_after_decide: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(cmd.decide))
      else $error("result strobe without a decision");

   a_best_never_rises: assert property (@(posedge clock) disable iff (reset)
      (cmd.decide && is_trial_ff) |=> (best_ff <= $past(best_ff)))
      else $error("best cost rose on a trial");

   a_improved_is_best: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_improved_ff) |-> (rsp_total_cost_ff == best_ff))
      else $error("improved result does not match best cost");

   a_one_place_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_step, cmd.init_step, cmd.swap_wr_a, cmd.swap_wr_b,
                cmd.restore_a, cmd.restore_b}))
      else $error("placement write sources collide");

endmodule

// File: rtl/placement_swap_search_top.sv
// placement swap search: holds a traffic matrix and a slot placement and scores
// swap trials by cross-group traffic.
// depends on pss_pkg, pss_ram, pss_ctrl and pss_datapath.
//
// channels: an item is taken when start is high and busy is low. kind load
// writes one matrix entry in that cycle and gives no result. kind start resets
// the placement to identity and returns the baseline cost. kind trial swaps two
// slots, returns the new cost and an improved flag, and undoes the swap unless
// the cost fell below the best cost. csr_write_enable writes rank_count (index
// 0) or group_size (index 1); the user must write only while the block is idle,
// the block itself does not enforce it. results: rsp_strobe marks a result for
// one cycle; the receiver cannot stall. flow: one item at a time, the next
// transfer waits for busy low; a load is taken without busy rising and the next
// item may follow it. after a trial, busy falls with the result, or after the
// RESTORE_A and RESTORE_B states when the swap is undone. after a start, busy
// falls with the result. the cost walk reads one matrix entry per cycle from
// the single read port of the ram.
// reset: a clearing pass over all MAX_RANKS*MAX_RANKS matrix entries zeroes the
// matrix and writes the identity placement; busy stays high during it.

module placement_swap_search_top #(
   parameter int MAX_RANKS   = 64,
   parameter int VOLUME_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_kind,
   input  logic [5:0]                          req_row_rank,
   input  logic [5:0]                          req_col_rank,
   input  logic [31:0]                         req_volume,
   input  logic [5:0]                          req_swap_first,
   input  logic [5:0]                          req_swap_second,
   output logic                                rsp_strobe,
   output logic [pss_pkg::COST_BITS-1:0]       rsp_total_cost,
   output logic                                rsp_improved,
   input  logic                                csr_write_enable,
   input  logic [pss_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [pss_pkg::CFG_BITS-1:0]        csr_data
);
   import pss_pkg::*;

   pss_cmd_type    cmd;
   pss_status_type status;

   pss_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .kind   (req_kind),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   pss_datapath #(
      .MAX_RANKS   (MAX_RANKS),
      .VOLUME_BITS (VOLUME_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_kind),
      .req_row_rank     (req_row_rank),
      .req_col_rank     (req_col_rank),
      .req_volume       (req_volume),
      .req_swap_first   (req_swap_first),
      .req_swap_second  (req_swap_second),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_total_cost   (rsp_total_cost),
      .rsp_improved     (rsp_improved)
   );

endmodule

// File: tb/testbench.sv
// testbench for placement_swap_search_top: load, start and swap-trial commands, with the
// matrix, placement and best cost mirrored here to score each cost result
// depends on pss_pkg and the placement_swap_search_top rtl

module testbench;
   import pss_pkg::*;

   localparam int         RANK_LIMIT    = 64;
   localparam logic [1:0] KIND_UNUSED   = 2'd3;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         DRAIN_CYCLES  = 40;
   localparam int         QUIET_LIMIT   = 25000;
   localparam int         PLAN_ROWS     = 29;
   localparam int         PHASE_COUNT   = 13;
   localparam cost_type   COST_CEILING  = '1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [5:0]  row_rank;
      logic [5:0]  col_rank;
      logic [31:0] volume;
      logic [5:0]  swap_first;
      logic [5:0]  swap_second;
   } search_cmd_type;

   typedef struct packed {
      cost_type total_cost;
      logic     improved;
   } cost_report_type;

   typedef struct packed {
      logic                      reg_write;
      logic [CSR_INDEX_BITS-1:0] reg_index;
      logic [CFG_BITS-1:0]       reg_value;
      search_cmd_type            cmd;
      logic                      fixed;
      cost_report_type           fixed_report;
   } plan_row_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [1:0]                req_kind = '0;
   logic [5:0]                req_row_rank = '0;
   logic [5:0]                req_col_rank = '0;
   logic [31:0]               req_volume = '0;
   logic [5:0]                req_swap_first = '0;
   logic [5:0]                req_swap_second = '0;
   logic                      rsp_strobe;
   cost_type                  rsp_total_cost;
   logic                      rsp_improved;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]       csr_data = '0;

   // mirrored block state
   logic [31:0]         traffic_copy [RANK_LIMIT][RANK_LIMIT];
   logic [5:0]          slot_rank [RANK_LIMIT];
   cost_type            best_cost_copy;
   logic [CFG_BITS-1:0] rank_count_cfg;
   logic [CFG_BITS-1:0] group_size_cfg;

   cost_report_type reports_due [$];
   cost_report_type report_head;
   bit              failed = 1'b0;
   int unsigned     quiet_cycles = 0;

   placement_swap_search_top #(
      .MAX_RANKS   (RANK_LIMIT),
      .VOLUME_BITS (32)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_row_rank     (req_row_rank),
      .req_col_rank     (req_col_rank),
      .req_volume       (req_volume),
      .req_swap_first   (req_swap_first),
      .req_swap_second  (req_swap_second),
      .rsp_strobe       (rsp_strobe),
      .rsp_total_cost   (rsp_total_cost),
      .rsp_improved     (rsp_improved),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned slots_in_use();
      return (rank_count_cfg > RANK_LIMIT) ? RANK_LIMIT : rank_count_cfg;
   endfunction

   // group size zero puts every slot in a group of its own
   function automatic int unsigned group_of(int unsigned slot);
      return (group_size_cfg == 0) ? slot : slot % group_size_cfg;
   endfunction

   function automatic cost_type cross_group_cost();
      int unsigned n = slots_in_use();
      cost_type    sum = '0;
      cost_type    vol;
      for (int unsigned i = 0; i < n; i++) begin
         for (int unsigned j = 0; j < n; j++) begin
            if (group_of(i) != group_of(j)) begin
               vol = cost_type'(traffic_copy[slot_rank[i]][slot_rank[j]]);
               sum = (sum > COST_CEILING - vol) ? COST_CEILING : sum + vol;
            end
         end
      end
      return sum;
   endfunction

   function automatic void identity_placement();
      for (int k = 0; k < RANK_LIMIT; k++) slot_rank[k] = 6'(k);
   endfunction

   function automatic void exchange_slots(int unsigned a, int unsigned b);
      logic [5:0] held = slot_rank[a];
      slot_rank[a] = slot_rank[b];
      slot_rank[b] = held;
   endfunction

   // returns 1 when the command gives a cost result
   function automatic bit apply_search_cmd(input search_cmd_type cmd,
                                           output cost_report_type report);
      int unsigned n = slots_in_use();
      bit          in_range;
      report = '0;
      case (cmd.kind)
         KIND_LOAD: begin
            traffic_copy[cmd.row_rank][cmd.col_rank] = cmd.volume;
            return 1'b0;
         end
         KIND_START: begin
            identity_placement();
            best_cost_copy = cross_group_cost();
            report.total_cost = best_cost_copy;
            return 1'b1;
         end
         KIND_TRIAL: begin
            // a slot outside the active ranks leaves the placement as it is
            in_range = (cmd.swap_first < n) && (cmd.swap_second < n);
            if (in_range) exchange_slots(cmd.swap_first, cmd.swap_second);
            report.total_cost = cross_group_cost();
            report.improved = report.total_cost < best_cost_copy;
            if (report.improved) begin
               best_cost_copy = report.total_cost;
            end else if (in_range) begin
               exchange_slots(cmd.swap_first, cmd.swap_second);
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic plan_row_type cmd_row(logic [1:0] kind, logic [5:0] row_rank,
                                            logic [5:0] col_rank, logic [31:0] volume,
                                            logic [5:0] slot_a, logic [5:0] slot_b);
      plan_row_type entry = '0;
      entry.cmd.kind        = kind;
      entry.cmd.row_rank    = row_rank;
      entry.cmd.col_rank    = col_rank;
      entry.cmd.volume      = volume;
      entry.cmd.swap_first  = slot_a;
      entry.cmd.swap_second = slot_b;
      return entry;
   endfunction

   function automatic plan_row_type reg_row(logic [CSR_INDEX_BITS-1:0] index,
                                            logic [CFG_BITS-1:0] value);
      plan_row_type entry = '0;
      entry.reg_write = 1'b1;
      entry.reg_index = index;
      entry.reg_value = value;
      return entry;
   endfunction

   function automatic plan_row_type known_row(plan_row_type entry, cost_type cost,
                                              logic improved);
      entry.fixed = 1'b1;
      entry.fixed_report.total_cost = cost;
      entry.fixed_report.improved = improved;
      return entry;
   endfunction

   function automatic search_cmd_type random_search_cmd(int unsigned seq, int unsigned span,
                                                        int unsigned n_live);
      search_cmd_type cmd;
      int unsigned pick = $urandom_range(0, 99);
      int unsigned top = (n_live == 0) ? RANK_LIMIT - 1 : n_live - 1;
      cmd.row_rank    = 6'($urandom_range(0, top));
      cmd.col_rank    = 6'($urandom_range(0, top));
      cmd.volume      = $urandom;
      cmd.swap_first  = 6'($urandom_range(0, top));
      cmd.swap_second = 6'($urandom_range(0, top));
      // a run of loads, then a start, then mostly trials
      if (seq < span / 4) begin
         cmd.kind = KIND_LOAD;
      end else if (seq == span / 4 || pick < 8) begin
         cmd.kind = KIND_START;
      end else if (pick < 32) begin
         cmd.kind = KIND_LOAD;
      end else if (pick < 90) begin
         cmd.kind = KIND_TRIAL;
      end else if (pick < 97) begin
         cmd.kind = KIND_TRIAL;
         cmd.swap_first  = 6'($urandom);
         cmd.swap_second = 6'($urandom);
      end else begin
         cmd.kind = KIND_UNUSED;
      end
      if (cmd.kind == KIND_LOAD) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            cmd.row_rank = 6'($urandom);
            cmd.col_rank = 6'($urandom);
         end else if (pick < 18) begin
            cmd.volume = '0;
         end else if (pick < 26) begin
            cmd.volume = '1;
         end
      end
      return cmd;
   endfunction

   task automatic issue_cmd(input search_cmd_type cmd, input int unsigned idle_pct,
                            input bit fixed, input cost_report_type fixed_report);
      cost_report_type report;
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      start           <= 1'b1;
      req_kind        <= cmd.kind;
      req_row_rank    <= cmd.row_rank;
      req_col_rank    <= cmd.col_rank;
      req_volume      <= cmd.volume;
      req_swap_first  <= cmd.swap_first;
      req_swap_second <= cmd.swap_second;
      do @(posedge clock); while (busy);
      if (apply_search_cmd(cmd, report)) reports_due.push_back(fixed ? fixed_report : report);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CFG_BITS-1:0] value);
      start <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
      // a load or a swap undo may still be finishing after the last result
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_RANK_COUNT) rank_count_cfg = value;
      else group_size_cfg = value;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (!reset && rsp_strobe) begin
         if (reports_due.size() == 0) begin
            $display("%0t: result with none due: total_cost %0d improved %0b",
                     $time, rsp_total_cost, rsp_improved);
            failed <= 1'b1;
         end else begin
            report_head = reports_due.pop_front();
            if (rsp_total_cost !== report_head.total_cost) begin
               $display("%0t: total_cost expected %0d actual %0d",
                        $time, report_head.total_cost, rsp_total_cost);
               failed <= 1'b1;
            end
            if (rsp_improved !== report_head.improved) begin
               $display("%0t: improved expected %0b actual %0b",
                        $time, report_head.improved, rsp_improved);
               failed <= 1'b1;
            end
         end
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      plan_row_type        plan [PLAN_ROWS];
      logic [CFG_BITS-1:0] phase_ranks [PHASE_COUNT] =
         '{7'd5, 7'd8, 7'd6, 7'd1, 7'd12, 7'd3, 7'd64, 7'd127, 7'd0, 7'd16, 7'd10, 7'd2, 7'd7};
      logic [CFG_BITS-1:0] phase_groups [PHASE_COUNT] =
         '{7'd2, 7'd3, 7'd0, 7'd1, 7'd5, 7'd127, 7'd16, 7'd64, 7'd7, 7'd4, 7'd1, 7'd64, 7'd0};
      int unsigned         phase_idle [PHASE_COUNT] =
         '{0, 72, 33, 0, 72, 33, 0, 72, 33, 0, 72, 33, 0};
      int unsigned         phase_items [PHASE_COUNT] =
         '{12, 12, 10, 8, 12, 8, 5, 4, 6, 12, 10, 8, 11};
      int unsigned         made;
      search_cmd_type      cmd;

      for (int r = 0; r < RANK_LIMIT; r++) begin
         for (int c = 0; c < RANK_LIMIT; c++) traffic_copy[r][c] = '0;
      end
      identity_placement();
      best_cost_copy = '0;
      rank_count_cfg = RANK_COUNT_RESET;
      group_size_cfg = GROUP_SIZE_RESET;

      plan = '{
         // trial before any start: best cost is zero, nothing can improve
         known_row(cmd_row(KIND_TRIAL, 6'd0, 6'd0, 32'd0, 6'd0, 6'd1), '0, 1'b0),
         cmd_row(KIND_UNUSED, 6'd63, 6'd63, 32'hFFFF_FFFF, 6'd63, 6'd63),
         cmd_row(KIND_LOAD, 6'd0, 6'd63, 32'hFFFF_FFFF, 6'd0, 6'd0),
         cmd_row(KIND_LOAD, 6'd63, 6'd0, 32'd0, 6'd0, 6'd0),
         cmd_row(KIND_LOAD, 6'd63, 6'd63, 32'h8000_0001, 6'd0, 6'd0),
         reg_row(CSR_RANK_COUNT, 7'd4),
         reg_row(CSR_GROUP_SIZE, 7'd2),
         cmd_row(KIND_LOAD, 6'd0, 6'd1, 32'd100, 6'd0, 6'd0),
         cmd_row(KIND_LOAD, 6'd1, 6'd0, 32'd20, 6'd0, 6'd0),
         cmd_row(KIND_LOAD, 6'd0, 6'd2, 32'd7, 6'd0, 6'd0),
         cmd_row(KIND_LOAD, 6'd2, 6'd3, 32'd3, 6'd0, 6'd0),
         cmd_row(KIND_START, 6'd0, 6'd0, 32'd0, 6'd0, 6'd0),
         cmd_row(KIND_TRIAL, 6'd0, 6'd0, 32'd0, 6'd1, 6'd2),
         cmd_row(KIND_TRIAL, 6'd0, 6'd0, 32'd0, 6'd0, 6'd1),
         cmd_row(KIND_TRIAL, 6'd0, 6'd0, 32'd0, 6'd2, 6'd2),
         cmd_row(KIND_TRIAL, 6'd0, 6'd0, 32'd0, 6'd0, 6'd4),
         cmd_row(KIND_TRIAL, 6'd0, 6'd0, 32'd0, 6'd63, 6'd63),
         reg_row(CSR_GROUP_SIZE, 7'd0),
         cmd_row(KIND_START, 6'd0, 6'd0, 32'd0, 6'd0, 6'd0),
         cmd_row(KIND_TRIAL, 6'd0, 6'd0, 32'd0, 6'd1, 6'd3),
         // no slots in use: every cost is zero
         reg_row(CSR_RANK_COUNT, 7'd0),
         known_row(cmd_row(KIND_START, 6'd0, 6'd0, 32'd0, 6'd0, 6'd0), '0, 1'b0),
         known_row(cmd_row(KIND_TRIAL, 6'd0, 6'd0, 32'd0, 6'd0, 6'd0), '0, 1'b0),
         // rank count past the matrix acts as the full matrix
         reg_row(CSR_RANK_COUNT, 7'd127),
         reg_row(CSR_GROUP_SIZE, 7'd1),
         known_row(cmd_row(KIND_START, 6'd0, 6'd0, 32'd0, 6'd0, 6'd0), '0, 1'b0),
         reg_row(CSR_GROUP_SIZE, 7'd127),
         cmd_row(KIND_START, 6'd0, 6'd0, 32'd0, 6'd0, 6'd0),
         cmd_row(KIND_TRIAL, 6'd0, 6'd0, 32'd0, 6'd0, 6'd63)
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         if (plan[r].reg_write) begin
            write_register(plan[r].reg_index, plan[r].reg_value);
         end else begin
            issue_cmd(plan[r].cmd, 0, plan[r].fixed, plan[r].fixed_report);
         end
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_register(CSR_RANK_COUNT, phase_ranks[p]);
         write_register(CSR_GROUP_SIZE, phase_groups[p]);
         made = 0;
         while (made < phase_items[p]) begin
            cmd = random_search_cmd(made, phase_items[p], slots_in_use());
            issue_cmd(cmd, phase_idle[p], 1'b0, '0);
            if (cmd.kind != KIND_UNUSED) made++;
         end
      end

      start <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
